### design/scfla_pkg.sv
`timescale 1ns / 1ps
package scfla_pkg;
  localparam int SIZE_BITS = 12;
  localparam int CLS_BITS = 10;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;
  localparam logic [1:0] REG_SMALL = 2'd0;
  localparam logic [1:0] REG_MIDDLE = 2'd1;
  localparam logic [1:0] REG_LARGE = 2'd2;

  typedef struct packed {
    logic [CLS_BITS-1:0] sz0;
    logic [CLS_BITS-1:0] sz1;
    logic [CLS_BITS-1:0] sz2;
  } cls_cfg_t;

  // entry in the command queue between front and back
  typedef struct packed {
    logic                 op;
    logic [SIZE_BITS-1:0] size;
  } cmd_t;
endpackage

### design/scfla_front.sv
`timescale 1ns / 1ps
// Two-entry command queue; front end of the allocator.
module scfla_front #(
  parameter int OFFSET_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  scfla_pkg::cmd_t         in_cmd_i,
  input  logic [OFFSET_BITS-1:0]  in_ofs_i,
  output logic                    q_valid_o,
  input  logic                    q_pop_i,
  output scfla_pkg::cmd_t         q_cmd_o,
  output logic [OFFSET_BITS-1:0]  q_ofs_o
);
  import scfla_pkg::*;
  cmd_t                   cmd_q [2];
  logic [OFFSET_BITS-1:0] ofs_q [2];
  logic                   wr_q, rd_q;
  logic [1:0]             cnt_q;
  logic                   push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o = cmd_q[rd_q];
  assign q_ofs_o = ofs_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_q] <= in_cmd_i;
      ofs_q[wr_q] <= in_ofs_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop_i |-> q_valid_o)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !q_pop_i) |=> cnt_q == 2'd2)
    else $error("full queue lost entry");
endmodule

### design/scfla_back.sv
`timescale 1ns / 1ps
// Back end: pop, carve loop (one push per cycle), result register.
module scfla_back #(
  parameter int STACK_DEPTH = 256,
  parameter int OFFSET_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  scfla_pkg::cls_cfg_t     cfg_i,
  input  logic                    q_valid_i,
  output logic                    q_pop_o,
  input  scfla_pkg::cmd_t         q_cmd_i,
  input  logic [OFFSET_BITS-1:0]  q_ofs_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic [OFFSET_BITS-1:0]  block_ofs_o,
  output logic [scfla_pkg::SIZE_BITS-1:0] discarded_o
);
  import scfla_pkg::*;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP = 3'd1;
  localparam logic [2:0] S_RD = 3'd2;
  localparam logic [2:0] S_CARVE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [OFFSET_BITS-1:0] stk0 [STACK_DEPTH];
  logic [OFFSET_BITS-1:0] stk1 [STACK_DEPTH];
  logic [OFFSET_BITS-1:0] stk2 [STACK_DEPTH];
  logic [CW-1:0] cnt_q [3];
  logic [OFFSET_BITS-1:0] rd0_q, rd1_q, rd2_q;
  logic [AW-1:0] raddr0, raddr1, raddr2;

  logic [2:0] state_q;
  logic [1:0] cls_q;
  logic [OFFSET_BITS-1:0] ofs_q;
  logic [SIZE_BITS-1:0] left_q, lost_q, req_q;
  logic drop_q;
  logic ov_q;
  logic [1:0] st_q;
  logic [OFFSET_BITS-1:0] blk_q;
  logic [SIZE_BITS-1:0] disc_q;
  logic [1:0] out_st_q;
  logic [OFFSET_BITS-1:0] out_blk_q;
  logic [SIZE_BITS-1:0] out_disc_q;
  logic done_fire;

  logic [SIZE_BITS-1:0] e0, e1, e2, csz;
  logic [1:0] ccls;
  logic [OFFSET_BITS-1:0] blk_rd;

  always_comb begin
    e0 = (cfg_i.sz0 == '0) ? SIZE_BITS'(1) : SIZE_BITS'(cfg_i.sz0);
    e1 = (cfg_i.sz1 == '0) ? SIZE_BITS'(1) : SIZE_BITS'(cfg_i.sz1);
    e2 = (cfg_i.sz2 == '0) ? SIZE_BITS'(1) : SIZE_BITS'(cfg_i.sz2);
    if (left_q >= e2) begin
      ccls = 2'd2; csz = e2;
    end else if (left_q >= e1) begin
      ccls = 2'd1; csz = e1;
    end else begin
      ccls = 2'd0; csz = e0;
    end
    case (cls_q)
      2'd0: blk_rd = rd0_q;
      2'd1: blk_rd = rd1_q;
      default: blk_rd = rd2_q;
    endcase
  end

  logic pushing;
  logic [AW-1:0] waddr;
  assign pushing = (state_q == S_CARVE) && (left_q >= e0) &&
                   (cnt_q[ccls] < CW'(STACK_DEPTH));
  assign waddr = cnt_q[ccls][AW-1:0];
  // top of stack sits one below the count
  assign raddr0 = cnt_q[0][AW-1:0] - 1'b1;
  assign raddr1 = cnt_q[1][AW-1:0] - 1'b1;
  assign raddr2 = cnt_q[2][AW-1:0] - 1'b1;
  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign done_fire = (state_q == S_DONE) && (!ov_q || !out_stall_i);
  assign out_valid_o = ov_q;
  assign status_o = out_st_q;
  assign block_ofs_o = out_blk_q;
  assign discarded_o = out_disc_q;

  always_ff @(posedge clk_i) begin
    if (pushing && ccls == 2'd0) stk0[waddr] <= ofs_q;
    if (pushing && ccls == 2'd1) stk1[waddr] <= ofs_q;
    if (pushing && ccls == 2'd2) stk2[waddr] <= ofs_q;
    rd0_q <= stk0[raddr0];
    rd1_q <= stk1[raddr1];
    rd2_q <= stk2[raddr2];
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_st_q <= st_q;
      out_blk_q <= blk_q;
      out_disc_q <= disc_q;
    end
    case (state_q)
      S_IDLE: if (q_valid_i) begin
        req_q <= q_cmd_i.size;
        left_q <= q_cmd_i.size;
        ofs_q <= q_ofs_i;
        lost_q <= '0;
        drop_q <= 1'b0;
        blk_q <= '0;
        st_q <= ST_OK;
      end
      S_POP: begin
        if (req_q <= e0 && cnt_q[0] != '0) begin
          cls_q <= 2'd0; left_q <= e0 - req_q;
        end else if (req_q <= e1 && cnt_q[1] != '0) begin
          cls_q <= 2'd1; left_q <= e1 - req_q;
        end else if (req_q <= e2 && cnt_q[2] != '0) begin
          cls_q <= 2'd2; left_q <= e2 - req_q;
        end else begin
          st_q <= ST_NOFIT; left_q <= '0;
        end
      end
      S_RD: begin
        blk_q <= blk_rd;
        ofs_q <= blk_rd + OFFSET_BITS'(req_q);
      end
      S_CARVE: if (left_q >= e0) begin
        if (!pushing) begin
          lost_q <= lost_q + csz;
          drop_q <= 1'b1;
        end
        left_q <= left_q - csz;
        ofs_q <= ofs_q + OFFSET_BITS'(csz);
      end else begin
        disc_q <= lost_q + left_q;
        if (st_q != ST_NOFIT) st_q <= drop_q ? ST_DROP : ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
      cnt_q[0] <= '0; cnt_q[1] <= '0; cnt_q[2] <= '0;
    end else begin
      ov_q <= done_fire || (ov_q && out_stall_i);
      case (state_q)
        S_IDLE: if (q_valid_i)
          state_q <= (q_cmd_i.op == OP_FREE) ? S_CARVE : S_POP;
        S_POP: begin
          if (req_q <= e0 && cnt_q[0] != '0) begin
            cnt_q[0] <= cnt_q[0] - 1'b1; state_q <= S_RD;
          end else if (req_q <= e1 && cnt_q[1] != '0) begin
            cnt_q[1] <= cnt_q[1] - 1'b1; state_q <= S_RD;
          end else if (req_q <= e2 && cnt_q[2] != '0) begin
            cnt_q[2] <= cnt_q[2] - 1'b1; state_q <= S_RD;
          end else state_q <= S_CARVE;
        end
        S_RD: state_q <= S_CARVE;
        S_CARVE: begin
          if (pushing) cnt_q[ccls] <= cnt_q[ccls] + 1'b1;
          if (left_q < e0) state_q <= S_DONE;
        end
        S_DONE: if (done_fire) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[0] <= CW'(STACK_DEPTH) && cnt_q[1] <= CW'(STACK_DEPTH) &&
    cnt_q[2] <= CW'(STACK_DEPTH))
    else $error("stack count past depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> ov_q)
    else $error("stalled result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == S_POP || state_q == S_CARVE)
    else $error("pop without dispatch");
endmodule

### design/size_class_free_list_allocator.sv
`timescale 1ns / 1ps
// Channel | signals                                  | direction
// in      | in_valid_i/in_stall_o, op/req_size/offset | item in
// out     | out_valid_o/out_stall_i, status/ofs/disc  | result out
// cfg     | APB psel/penable/pwrite/paddr/pwdata      | class sizes
// Free: the back end carves the region into pieces (one stack push per cycle, one
// write port per class stack). Alloc: pop, registered stack read, then carve
// of the tail pieces. A two-entry queue decouples accept from the back end.
// Reset clears counts and config to 16/64/256; stacks are not cleared.
// A stalled result holds in the output register; the queue keeps accepting until full.
module size_class_free_list_allocator #(
  parameter int STACK_DEPTH = 256,
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   op_i,
  input  logic [11:0]            req_size_i,
  input  logic [OFFSET_BITS-1:0] region_offset_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             status_o,
  output logic [OFFSET_BITS-1:0] block_offset_o,
  output logic [11:0]            discarded_units_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import scfla_pkg::*;
  cls_cfg_t cfg_q;
  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;
  logic [OFFSET_BITS-1:0] q_ofs;
  logic [1:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[3:2];
  assign in_cmd.op = op_i;
  assign in_cmd.size = req_size_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sz0 <= CLS_BITS'(16);
      cfg_q.sz1 <= CLS_BITS'(64);
      cfg_q.sz2 <= CLS_BITS'(256);
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_SMALL: cfg_q.sz0 <= {3'b0, pwdata[6:0]};
        REG_MIDDLE: cfg_q.sz1 <= {2'b0, pwdata[7:0]};
        REG_LARGE: cfg_q.sz2 <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_SMALL: prdata = {22'b0, cfg_q.sz0};
      REG_MIDDLE: prdata = {22'b0, cfg_q.sz1};
      REG_LARGE: prdata = {22'b0, cfg_q.sz2};
      default: prdata = '0;
    endcase
  end

  scfla_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_cmd_i(in_cmd),
    .in_ofs_i(region_offset_i), .q_valid_o(q_valid), .q_pop_i(q_pop),
    .q_cmd_o(q_cmd), .q_ofs_o(q_ofs));

  scfla_back #(.STACK_DEPTH(STACK_DEPTH), .OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_cmd_i(q_cmd), .q_ofs_i(q_ofs), .out_valid_o, .out_stall_i,
    .status_o, .block_ofs_o(block_offset_o), .discarded_o(discarded_units_o));
endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import scfla_pkg::*;

  localparam int DEPTH      = 256;
  localparam int CYCLE_CAP  = 20000000;
  localparam int SETTLE     = 40;   // idle margin after the last result

  // Result of one transfer on the output channel
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] block;
    logic [11:0] discarded;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_ALLOC;
  logic [11:0] req_size = '0;
  logic [15:0] region_ofs = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [15:0] block_ofs;
  logic [11:0] discarded;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  size_class_free_list_allocator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .op_i(op), .req_size_i(req_size), .region_offset_i(region_ofs),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .block_offset_o(block_ofs), .discarded_units_o(discarded),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: mirror of class sizes, the three offset stacks and their counts
  // ---------------------------------------------------------------------------
  logic [6:0]  cls_small = 7'd16;
  logic [7:0]  cls_middle = 8'd64;
  logic [9:0]  cls_large = 10'd256;
  logic [15:0] free_stack [3][DEPTH];
  int          free_count [3] = '{0, 0, 0};
  bit          piece_dropped;

  alloc_result_t expected_results[$];
  int errors = 0;
  int n_items = 0, n_results = 0, n_drops = 0, n_nofit = 0;

  // a zero register behaves as size 1
  function automatic int class_units(int c);
    int v;
    v = (c == 0) ? cls_small : (c == 1) ? cls_middle : cls_large;
    return (v == 0) ? 1 : v;
  endfunction

  // Split a region into class pieces, highest-numbered fitting class first.
  // Returns units that ended up on no stack.
  function automatic int carve_region(logic [15:0] ofs, int left);
    int lost, c, sz;
    lost = 0;
    while (left >= class_units(0)) begin
      c = 2;
      while (c > 0 && left < class_units(c)) c--;
      sz = class_units(c);
      if (free_count[c] < DEPTH) begin
        free_stack[c][free_count[c]] = ofs;
        free_count[c]++;
      end else begin
        lost += sz;
        piece_dropped = 1'b1;
      end
      left -= sz;
      ofs += sz[15:0];   // wraps at 16 bits
    end
    return lost + left;
  endfunction

  function automatic alloc_result_t apply_request(logic o, logic [11:0] sz,
                                                  logic [15:0] ofs);
    alloc_result_t r;
    int lost, c, csz;
    r = '0;
    lost = 0;
    piece_dropped = 1'b0;
    if (o == OP_FREE) begin
      lost = carve_region(ofs, sz);
      r.status = piece_dropped ? ST_DROP : ST_OK;
    end else begin
      r.status = ST_NOFIT;
      for (c = 0; c < 3; c++) begin
        csz = class_units(c);
        if (sz <= csz && free_count[c] > 0) begin
          free_count[c]--;
          r.block = free_stack[c][free_count[c]];
          if (csz > sz) lost = carve_region(r.block + sz, csz - sz);
          r.status = piece_dropped ? ST_DROP : ST_OK;
          break;
        end
      end
    end
    r.discarded = lost[11:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  bit hold_req = 0, hold_seen = 0;
  int hold_left = 0;
  int rx_mode = 0, rx_window = 0;   // 0 busy stalls, 1 no stalls, 2 sparse long stalls
  int rx_gap = 0;

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else begin
      if (rx_window == 0) begin
        rx_window <= $urandom_range(100, 20);
        rx_mode <= $urandom_range(2, 0);
      end else
        rx_window <= rx_window - 1;
      if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_stall <= (rx_gap > 1);
      end else if (rx_mode == 0 && $urandom_range(3, 0) == 0) begin
        out_stall <= 1'b1;
        rx_gap <= $urandom_range(3, 1);
      end else if (rx_mode == 2 && $urandom_range(30, 0) == 0) begin
        out_stall <= 1'b1;
        rx_gap <= $urandom_range(40, 10);
      end else
        out_stall <= 1'b0;
    end
  end

  // Result checker: every output transfer against the oldest expectation
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d ofs=%0h disc=%0d",
                 $time, status, block_ofs, discarded);
      end else begin
        exp_r = expected_results.pop_front();
        if (status !== exp_r.status) begin
          errors++;
          $display("%0t: status expected %0d got %0d", $time, exp_r.status, status);
        end
        if (block_ofs !== exp_r.block) begin
          errors++;
          $display("%0t: block_offset expected %0h got %0h", $time, exp_r.block, block_ofs);
        end
        if (discarded !== exp_r.discarded) begin
          errors++;
          $display("%0t: discarded_units expected %0d got %0d",
                   $time, exp_r.discarded, discarded);
        end
      end
    end
  end

  // Watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  int tx_mode = 0;   // 0 short gaps, 1 back to back, 2 rare long gaps

  task automatic send_request(logic o, logic [11:0] sz, logic [15:0] ofs);
    alloc_result_t r;
    int gap;
    in_valid <= 1'b1;
    op <= o;
    req_size <= sz;
    region_ofs <= ofs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = apply_request(o, sz, ofs);
    if (r.status == ST_DROP) n_drops++;
    if (r.status == ST_NOFIT) n_nofit++;
    expected_results.push_back(r);
    n_items++;
    gap = 0;
    if (tx_mode == 0 && $urandom_range(2, 0) == 0) gap = $urandom_range(3, 1);
    if (tx_mode == 2 && $urandom_range(15, 0) == 0) gap = $urandom_range(50, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup then access; the predictor takes the masked value
  task automatic write_class(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SMALL:  cls_small = value[6:0];
      REG_MIDDLE: cls_middle = value[7:0];
      REG_LARGE:  cls_large = value[9:0];
      default: ;
    endcase
  endtask

  task automatic set_classes(int s, int m, int l);
    wait_drained();
    // random upper bits must be ignored by the register
    write_class(REG_SMALL,  {$urandom} & ~32'h7F | s[6:0]);
    write_class(REG_MIDDLE, {$urandom} & ~32'hFF | m[7:0]);
    write_class(REG_LARGE,  {$urandom} & ~32'h3FF | l[9:0]);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset classes 16/64/256: empty stacks, zero sizes, wrap, tails, misses
  task automatic test_reset_classes();
    send_request(OP_ALLOC, 12'd16, 16'h0);         // nothing free yet
    send_request(OP_FREE, 12'd0, 16'h1234);        // frees nothing
    send_request(OP_FREE, 12'hFFF, 16'hFFF0);      // offsets wrap past 0xFFFF
    send_request(OP_FREE, 12'd15, 16'h0100);       // below smallest class
    send_request(OP_ALLOC, 12'd0, 16'hFFFF);       // whole small block as tail
    send_request(OP_ALLOC, 12'd16, 16'h0);
    send_request(OP_ALLOC, 12'd17, 16'h0);         // middle block, tail re-freed
    send_request(OP_ALLOC, 12'd256, 16'h0);
    send_request(OP_ALLOC, 12'd257, 16'h0);        // larger than every class
    send_request(OP_ALLOC, 12'hFFF, 16'h0);
    send_request(OP_FREE, 12'd1, 16'h0);
    wait_drained();
  endtask

  // Register extremes, zero sizes, descending classes
  task automatic test_class_registers();
    set_classes(127, 255, 1023);
    send_request(OP_FREE, 12'hFFF, 16'h8000);
    send_request(OP_ALLOC, 12'd127, 16'h0);
    send_request(OP_ALLOC, 12'd1000, 16'h0);
    set_classes(0, 0, 0);                          // all act as size 1
    send_request(OP_FREE, 12'd3, 16'h00FF);
    send_request(OP_ALLOC, 12'd1, 16'h0);
    set_classes(100, 20, 5);                       // descending order
    send_request(OP_FREE, 12'd130, 16'h4000);
    send_request(OP_ALLOC, 12'd4, 16'h0);
    send_request(OP_ALLOC, 12'd101, 16'h0);
    wait_drained();
  endtask

  // Fill large then middle stacks; an alloc tail then lands on a full stack
  task automatic test_full_stacks();
    set_classes(1, 1, 1);
    send_request(OP_FREE, 12'd300, 16'h0);
    set_classes(1, 1, 300);
    send_request(OP_FREE, 12'd280, 16'h2000);
    set_classes(1, 1, 4);
    send_request(OP_ALLOC, 12'd2, 16'h0);
    wait_drained();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_classes(16, 64, 256);
    tx_mode = 1;
    hold_req = ~hold_req;
    repeat (30)
      send_request($urandom_range(1, 0) ? OP_FREE : OP_ALLOC,
                   12'($urandom_range(300, 0)), 16'($urandom));
    wait_drained();   // sender pauses until all results are back
  endtask

  // Random traffic: frees and allocs in equal share, mostly sized around the current classes
  task automatic test_random_phase(int items);
    int k, pick, sz;
    for (k = 0; k < items; k++) begin
      if (k % 40 == 0) tx_mode = $urandom_range(2, 0);
      pick = $urandom_range(99, 0);
      if (pick < 5)       sz = $urandom_range(4095, 0);
      else if (pick < 10) sz = 0;
      else                sz = $urandom_range(class_units(2) + class_units(1), 1);
      if (sz > 4095) sz = 4095;
      if ($urandom_range(99, 0) < 50)
        send_request(OP_FREE, sz[11:0], 16'($urandom));
      else
        send_request(OP_ALLOC, $urandom_range(99, 0) < 85 ?
                     12'($urandom_range(class_units(2), 0)) : sz[11:0], 16'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_classes();
    test_class_registers();
    test_full_stacks();
    test_backpressure();

    set_classes(16, 64, 256);
    test_random_phase(150);
    set_classes(1, 2, 3);
    test_random_phase(150);
    set_classes(127, 255, 1023);
    test_random_phase(150);
    set_classes(0, 0, 0);
    test_random_phase(100);
    set_classes(90, 30, 7);
    test_random_phase(150);
    set_classes($urandom_range(127, 1), $urandom_range(255, 1), $urandom_range(1023, 1));
    test_random_phase(150);
    wait_drained();

    $display("%0d requests, %0d results checked (%0d misses, %0d with dropped pieces)",
             n_items, n_results, n_nofit, n_drops);
    $display("covered register extremes, zero and descending classes, full stacks, stalls");
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
